FILE: rtl/gtq_pkg.sv
// shared types, codes and the gf(2^8) multiply for the triangular quadratic evaluator
`default_nettype none

package gtq_pkg;

  // widest index that any legal parameter set needs
  localparam int VAR_IDX_W  = 8;
  localparam int FORM_IDX_W = 6;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_VAR_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_LEN = 2'd1;

  localparam logic OP_VAR_LOAD = 1'b0;
  localparam logic OP_COEF     = 1'b1;

  localparam logic [6:0] VAR_COUNT_RST = 7'd42;
  localparam logic [5:0] BATCH_LEN_RST = 6'd28;

  localparam logic [7:0] GF_REDUCE = 8'h1B;

  // one classified transaction from the front to the back
  typedef struct packed {
    logic                  is_coef;
    logic                  first_col;
    logic                  row_end;
    logic                  eval_end;
    logic [VAR_IDX_W-1:0]  row;
    logic [VAR_IDX_W-1:0]  col;
    logic [FORM_IDX_W-1:0] form;
    logic [7:0]            data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] y;
    logic       last;
  } res_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] v;
    acc = '0;
    v   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ v;
      v = v[7] ? ((v << 1) ^ GF_REDUCE) : (v << 1);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gtq_fifo.sv
// small register queue used between the front and back and on the result side
`default_nettype none

module gtq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q;
  logic [AW-1:0]    rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gtq_front.sv
// front end: config registers, input accept and triangular index tracking
`default_nettype none

module gtq_front
  import gtq_pkg::*;
#(
  parameter int MAX_VARS  = 64,
  parameter int MAX_BATCH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  item_push_i,
  output logic                       item_full_o,
  input  wire logic                  operation_i,
  input  wire logic [7:0]            data_byte_i,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cmd_t                       cmd_o,
  output logic                       cmd_push_o,
  input  wire logic                  cmd_full_i
);

  localparam int NW  = $clog2(MAX_VARS + 1);
  localparam int VW  = $clog2(MAX_VARS);
  localparam int BBW = $clog2(MAX_BATCH + 1);
  localparam int BW  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

  logic [6:0]    var_count_q;
  logic [5:0]    batch_len_q;
  logic [NW-1:0] loaded_q;
  logic [VW-1:0] row_q;
  logic [VW-1:0] col_q;
  logic [BW-1:0] k_q;

  logic [NW-1:0]  n_eff;
  logic [BBW-1:0] b_eff;
  logic           item_acc;
  logic           is_coef;
  logic           vars_full;
  logic           k_last;
  logic           col_last;
  logic           row_last;
  logic           cfg_wr;
  logic           wr_var_count;
  logic           wr_batch_len;

  assign cfg_ready_o = 1'b1;
  assign item_full_o = cmd_full_i;
  assign item_acc    = item_push_i && !item_full_o;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign is_coef     = (operation_i == OP_COEF);

  always_comb begin
    wr_var_count = 1'b0;
    wr_batch_len = 1'b0;
    unique case (cfg_index_i)
      REG_VAR_COUNT: wr_var_count = cfg_wr;
      REG_BATCH_LEN: wr_batch_len = cfg_wr;
      default: ;
    endcase
  end

  // register values outside the supported range are clamped
  always_comb begin
    if (var_count_q == '0) begin
      n_eff = NW'(1);
    end else if (int'(var_count_q) > MAX_VARS) begin
      n_eff = NW'(MAX_VARS);
    end else begin
      n_eff = NW'(var_count_q);
    end
    if (batch_len_q == '0) begin
      b_eff = BBW'(1);
    end else if (int'(batch_len_q) > MAX_BATCH) begin
      b_eff = BBW'(MAX_BATCH);
    end else begin
      b_eff = BBW'(batch_len_q);
    end
  end

  assign vars_full = (loaded_q == n_eff);
  assign k_last    = (int'(k_q) + 1 == int'(b_eff));
  assign col_last  = (int'(col_q) + 1 == int'(n_eff));
  assign row_last  = (int'(row_q) + 1 == int'(n_eff));

  always_comb begin
    cmd_o.is_coef   = is_coef;
    cmd_o.first_col = (col_q == row_q);
    cmd_o.row_end   = k_last && col_last;
    cmd_o.eval_end  = k_last && col_last && row_last;
    cmd_o.row       = VAR_IDX_W'(row_q);
    cmd_o.col       = is_coef ? VAR_IDX_W'(col_q) : VAR_IDX_W'(loaded_q);
    cmd_o.form      = FORM_IDX_W'(k_q);
    cmd_o.data      = data_byte_i;
  end

  // early coefficients and surplus x bytes are dropped here
  assign cmd_push_o = item_acc && (is_coef ? vars_full : !vars_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_count_q <= VAR_COUNT_RST;
      batch_len_q <= BATCH_LEN_RST;
      loaded_q    <= '0;
      row_q       <= '0;
      col_q       <= '0;
      k_q         <= '0;
    end else begin
      if (wr_var_count) var_count_q <= cfg_data_i;
      if (wr_batch_len) batch_len_q <= cfg_data_i[5:0];
      if (wr_var_count || wr_batch_len) begin
        loaded_q <= '0;
        row_q    <= '0;
        col_q    <= '0;
        k_q      <= '0;
      end else if (cmd_push_o) begin
        if (!is_coef) begin
          loaded_q <= loaded_q + 1'b1;
        end else if (!k_last) begin
          k_q <= k_q + 1'b1;
        end else begin
          k_q <= '0;
          if (!col_last) begin
            col_q <= col_q + 1'b1;
          end else if (!row_last) begin
            row_q <= row_q + 1'b1;
            col_q <= row_q + 1'b1;
          end else begin
            loaded_q <= '0;
            row_q    <= '0;
            col_q    <= '0;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gtq_back.sv
// back end: x store, row and result accumulators, shared gf multiplier
`default_nettype none

module gtq_back
  import gtq_pkg::*;
#(
  parameter int MAX_VARS  = 64,
  parameter int MAX_BATCH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cmd_t      cmd_i,
  input  wire logic cmd_empty_i,
  output logic      cmd_pop_o,
  output res_t      res_o,
  output logic      res_push_o,
  input  wire logic res_full_i
);

  localparam int VW = $clog2(MAX_VARS);
  localparam int BW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COEF,
    ST_FOLD_RD,
    ST_FOLD_WR
  } state_e;

  state_e        state_q;
  cmd_t          cmd_q;
  logic [BW-1:0] k_q;

  logic [7:0] var_mem [MAX_VARS];
  logic [7:0] row_mem [MAX_BATCH];
  logic [7:0] res_mem [MAX_BATCH];
  logic [7:0] var_rd_q;
  logic [7:0] row_rd_q;
  logic [7:0] res_rd_q;

  logic          var_we;
  logic          var_re;
  logic [VW-1:0] var_waddr;
  logic [VW-1:0] var_raddr;
  logic          row_we;
  logic          row_re;
  logic [BW-1:0] row_waddr;
  logic [BW-1:0] row_raddr;
  logic          res_we;
  logic          res_re;
  logic [7:0]    mul_a;
  logic [7:0]    prod;
  logic [7:0]    row_wdata;
  logic [7:0]    fold_val;
  logic          k_last;
  logic          fold_step;

  assign k_last = (k_q == cmd_q.form[BW-1:0]);
  assign mul_a  = (state_q == ST_COEF) ? cmd_q.data : row_rd_q;
  assign prod   = gf_mul(mul_a, var_rd_q);

  // first column of a row and first row of an evaluation overwrite instead of accumulate
  assign row_wdata = cmd_q.first_col ? prod : (prod ^ row_rd_q);
  assign fold_val  = (cmd_q.row == '0) ? prod : (prod ^ res_rd_q);

  assign res_o.y    = fold_val;
  assign res_o.last = k_last;

  always_comb begin
    cmd_pop_o  = (state_q == ST_IDLE) && !cmd_empty_i;
    var_we     = cmd_pop_o && !cmd_i.is_coef;
    var_waddr  = cmd_i.col[VW-1:0];
    var_re     = 1'b0;
    var_raddr  = cmd_i.col[VW-1:0];
    row_re     = 1'b0;
    row_raddr  = cmd_i.form[BW-1:0];
    row_we     = 1'b0;
    row_waddr  = cmd_q.form[BW-1:0];
    res_re     = 1'b0;
    res_we     = 1'b0;
    res_push_o = 1'b0;
    fold_step  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        var_re = cmd_pop_o && cmd_i.is_coef;
        row_re = cmd_pop_o && cmd_i.is_coef;
      end
      ST_COEF: begin
        row_we    = 1'b1;
        // fetch x[row] for the fold that follows a row end
        var_re    = cmd_q.row_end;
        var_raddr = cmd_q.row[VW-1:0];
      end
      ST_FOLD_RD: begin
        row_re    = 1'b1;
        row_raddr = k_q;
        res_re    = 1'b1;
      end
      ST_FOLD_WR: begin
        res_push_o = cmd_q.eval_end && !res_full_i;
        res_we     = !cmd_q.eval_end;
        fold_step  = !cmd_q.eval_end || !res_full_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= '0;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o && cmd_i.is_coef) begin
            cmd_q   <= cmd_i;
            state_q <= ST_COEF;
          end
        end
        ST_COEF: begin
          k_q     <= '0;
          state_q <= cmd_q.row_end ? ST_FOLD_RD : ST_IDLE;
        end
        ST_FOLD_RD: begin
          state_q <= ST_FOLD_WR;
        end
        ST_FOLD_WR: begin
          if (fold_step) begin
            if (k_last) begin
              state_q <= ST_IDLE;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= ST_FOLD_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (var_we) var_mem[var_waddr] <= cmd_i.data;
    if (var_re) var_rd_q <= var_mem[var_raddr];
    if (row_we) row_mem[row_waddr] <= row_wdata;
    if (row_re) row_rd_q <= row_mem[row_raddr];
    if (res_we) res_mem[k_q] <= fold_val;
    if (res_re) res_rd_q <= res_mem[k_q];
  end

endmodule

`default_nettype wire

FILE: rtl/gf256_triangular_quadratic_eval.sv
// top level of the gf(2^8) triangular quadratic form evaluator
//
//   channel   direction  handshake               payload
//   input     in         push / full             operation_i, data_byte_i
//   result    out        empty / pop             y_byte_o, last_o
//   config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// an x byte is stored as it is popped; a coefficient takes a memory read, then a multiply-write
// each row end adds a fold through the accumulator memory ports, a read and a write per form
// the front takes items whenever its four-entry queue has room; the back stalls on a full
// result queue; reset is asynchronous, memories need no clearing pass
`default_nettype none

module gf256_triangular_quadratic_eval
  import gtq_pkg::*;
#(
  parameter int MAX_VARS  = 64,
  parameter int MAX_BATCH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  operation_i,
  input  wire logic [7:0]            data_byte_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [7:0]                 y_byte_o,
  output logic                       last_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;
  res_t back_res;
  res_t out_res;
  logic res_push;
  logic res_full;

  gtq_front #(
    .MAX_VARS (MAX_VARS),
    .MAX_BATCH(MAX_BATCH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_push_i(push),
    .item_full_o(full),
    .operation_i(operation_i),
    .data_byte_i(data_byte_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_o      (front_cmd),
    .cmd_push_o (cmd_push),
    .cmd_full_i (cmd_full)
  );

  gtq_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(front_cmd),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .rdata_o(back_cmd),
    .empty_o(cmd_empty)
  );

  gtq_back #(
    .MAX_VARS (MAX_VARS),
    .MAX_BATCH(MAX_BATCH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (back_cmd),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .res_o      (back_res),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  gtq_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(back_res),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(out_res),
    .empty_o(empty)
  );

  assign y_byte_o = out_res.y;
  assign last_o   = out_res.last;

endmodule

`default_nettype wire

FILE: rtl/gtq_checker.sv
// port-level assertions for the evaluator, bound to the top level
`default_nettype none

module gtq_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] y_byte_o,
  input wire logic       last_o,
  input wire logic       cfg_ready_o
);

  // a waiting result holds until it is taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(y_byte_o) && $stable(last_o)))
    else $error("result changed while waiting");

  // a waiting result never carries unknown bits
  a_res_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !$isunknown({y_byte_o, last_o}))
    else $error("unknown result value");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port stalled");

  // the queues are cleared by the edge after reset is seen
  a_reset_state: assert property (@(posedge clk_i)
    !rst_ni |=> (empty && !full))
    else $error("queues not cleared in reset");

endmodule

bind gf256_triangular_quadratic_eval gtq_checker u_checker (.*);

`default_nettype wire
